>>> src/handle_table_auto_key_defines.svh
// Assertion macros used by the handle table top level.
`ifndef HANDLE_TABLE_AUTO_KEY_DEFINES_SVH
`define HANDLE_TABLE_AUTO_KEY_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define HTAK_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define HTAK_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> src/htak_pkg.sv
// Types and constants of the handle table with self-assigned keys.
package htak_pkg;

    localparam int KEY_W          = 31;
    localparam int ITEM_IN_W      = 32;
    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_ITEM_WIDTH  = 32;

    localparam logic [KEY_W-1:0] FIRST_KEY = 31'd2;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_LOOKUP  = 2'd1,
        REQ_EXTRACT = 2'd2,
        REQ_OLDEST  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2,
        ST_NOKEYS = 2'd3
    } t_status;

    // What the scan of the table has found so far.
    typedef struct packed {
        logic hit;
        logic free;
    } t_scan_flags;

endpackage

>>> src/htak_req_if.sv
// Request channel of the handle table.
interface htak_req_if
    import htak_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [1:0]           req_type;
    logic [KEY_W-1:0]     key_in;
    logic [ITEM_IN_W-1:0] item_in;

    modport source (output valid, req_type, key_in, item_in, input ready);
    modport sink   (input valid, req_type, key_in, item_in, output ready);
endinterface

>>> src/htak_rsp_if.sv
// Result channel of the handle table.
interface htak_rsp_if
    import htak_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [KEY_W-1:0]     key_out;
    logic [ITEM_IN_W-1:0] item_out;
    logic                 empty_res;

    modport source (output valid, status, key_out, item_out, empty_res, input ready);
    modport sink   (input valid, status, key_out, item_out, empty_res, output ready);
endinterface

>>> src/htak_ram.sv
// Generic single-write, single-read RAM with registered read data.
module htak_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> src/htak_scan.sv
// Scan tracker: follows the slots read from the table and keeps the best match and the first free slot.
module htak_scan
    import htak_pkg::*;
#(
    parameter int ADDR_W = 4,
    parameter int ITEM_W = 32
) (
    input  logic              i_clk,
    input  logic              i_start,
    input  logic              i_en,
    input  t_req              i_req,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [ADDR_W-1:0] i_idx,
    input  logic              i_slot_vld,
    input  logic [KEY_W-1:0]  i_slot_key,
    input  logic [ITEM_W-1:0] i_slot_item,
    output t_scan_flags       o_flags,
    output logic [ADDR_W-1:0] o_hit_idx,
    output logic [KEY_W-1:0]  o_hit_key,
    output logic [ITEM_W-1:0] o_hit_item,
    output logic [ADDR_W-1:0] o_free_idx
);
    t_scan_flags       r_flags;
    logic [ADDR_W-1:0] r_hit_idx;
    logic [KEY_W-1:0]  r_hit_key;
    logic [ITEM_W-1:0] r_hit_item;
    logic [ADDR_W-1:0] r_free_idx;
    logic              take;
    logic              take_free;

    // For the oldest entry the smallest key wins; otherwise the first key match.
    always_comb begin
        if (i_req == REQ_OLDEST) begin
            take = i_slot_vld && (!r_flags.hit || (i_slot_key < r_hit_key));
        end else begin
            take = i_slot_vld && !r_flags.hit && (i_slot_key == i_key);
        end
        take_free = !i_slot_vld && !r_flags.free;
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_flags <= '0;
        end else if (i_en) begin
            if (take) begin
                r_flags.hit <= 1'b1;
                r_hit_idx   <= i_idx;
                r_hit_key   <= i_slot_key;
                r_hit_item  <= i_slot_item;
            end
            if (take_free) begin
                r_flags.free <= 1'b1;
                r_free_idx   <= i_idx;
            end
        end
    end

    assign o_flags    = r_flags;
    assign o_hit_idx  = r_hit_idx;
    assign o_hit_key  = r_hit_key;
    assign o_hit_item = r_hit_item;
    assign o_free_idx = r_free_idx;
endmodule

>>> src/handle_table_auto_key.sv
// Top level of the handle table, which hands out its own keys from 2 upwards.
// Every slot is read once, one a cycle through the single table read port; at most one is then written back:
// the result is registered in S_WRITE, after the states S_SCAN and S_DRAIN.
// The next request is taken only once the last has gone from S_WRITE back to S_IDLE,
// even while the last result waits; only a result still not taken holds up the write-back.
// Synchronous active-low reset, then a clearing pass frees every slot.
`include "handle_table_auto_key_defines.svh"

module handle_table_auto_key
    import htak_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ITEM_WIDTH  = DEF_ITEM_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    htak_req_if.sink    i_req,
    htak_rsp_if.source  o_rsp
);
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    // One table word: valid bit, key and item side by side.
    localparam int WORD_W = 1 + KEY_W + ITEM_WIDTH;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_WRITE
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_rd_vld;
    logic [ADDR_W-1:0]   r_rd_idx;
    t_req                r_req;
    logic [KEY_W-1:0]    r_key;
    logic [ITEM_WIDTH-1:0] r_item;
    logic [KEY_W-1:0]    r_next_key;
    logic [KEY_W-1:0]    n_next_key;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;

    logic                r_out_valid;
    t_status             r_status;
    t_status             n_status;
    logic [KEY_W-1:0]    r_kout;
    logic [KEY_W-1:0]    n_kout;
    logic [ITEM_IN_W-1:0] r_iout;
    logic [ITEM_IN_W-1:0] n_iout;
    logic                r_empty;

    logic                req_accept;
    logic                out_free;
    logic                do_result;
    logic [ITEM_WIDTH-1:0] item_store;
    logic [ITEM_IN_W-1:0]  hit_item_out;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;

    t_scan_flags         flags;
    logic [ADDR_W-1:0]   hit_idx;
    logic [KEY_W-1:0]    hit_key;
    logic [ITEM_WIDTH-1:0] hit_item;
    logic [ADDR_W-1:0]   free_idx;

    // The item field on the ports is 32 bits wide; the table keeps ITEM_WIDTH bits, zero-padded if wider.
    generate
        if (ITEM_WIDTH >= ITEM_IN_W) begin : g_item_wide
            assign item_store   = ITEM_WIDTH'(i_req.item_in);
            assign hit_item_out = hit_item[ITEM_IN_W-1:0];
        end else begin : g_item_narrow
            assign item_store   = i_req.item_in[ITEM_WIDTH-1:0];
            assign hit_item_out = ITEM_IN_W'(hit_item);
        end
    endgenerate

    // A request is taken only between scans; the result register frees the output side.
    assign i_req.ready = (r_state == S_IDLE);
    assign req_accept  = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign do_result   = (r_state == S_WRITE) && out_free;

    htak_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    htak_scan #(
        .ADDR_W (ADDR_W),
        .ITEM_W (ITEM_WIDTH)
    ) u_scan (
        .i_clk       (i_clk),
        .i_start     (req_accept),
        .i_en        (r_rd_vld),
        .i_req       (r_req),
        .i_key       (r_key),
        .i_idx       (r_rd_idx),
        .i_slot_vld  (ram_rdata[WORD_W-1]),
        .i_slot_key  (ram_rdata[WORD_W-2 -: KEY_W]),
        .i_slot_item (ram_rdata[ITEM_WIDTH-1:0]),
        .o_flags     (flags),
        .o_hit_idx   (hit_idx),
        .o_hit_key   (hit_key),
        .o_hit_item  (hit_item),
        .o_free_idx  (free_idx)
    );

    // Next state, the write-back and the result of the request in hand.
    always_comb begin
        n_state    = r_state;
        n_next_key = r_next_key;
        n_count    = r_count;
        n_status   = ST_OK;
        n_kout     = '0;
        n_iout     = '0;
        ram_we     = 1'b0;
        ram_waddr  = r_addr;
        ram_wdata  = '0;

        unique case (r_state)
            S_CLEAR: begin
                // Every slot is written free once after reset.
                ram_we = 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_addr == LAST_ADDR) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last slot's data arrives in this cycle.
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    unique case (r_req)
                        REQ_INSERT: begin
                            // Running out of keys is checked before a full table.
                            if (r_next_key < FIRST_KEY) begin
                                n_status = ST_NOKEYS;
                            end else if (!flags.free) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = free_idx;
                                ram_wdata  = {1'b1, r_next_key, r_item};
                                n_kout     = r_next_key;
                                n_next_key = r_next_key + KEY_W'(1);
                                n_count    = r_count + CNT_W'(1);
                            end
                        end
                        REQ_LOOKUP: begin
                            if (!flags.hit) begin
                                n_status = ST_ABSENT;
                            end else begin
                                n_iout = hit_item_out;
                            end
                        end
                        REQ_EXTRACT: begin
                            if (!flags.hit) begin
                                n_status = ST_ABSENT;
                            end else begin
                                n_iout    = hit_item_out;
                                ram_we    = 1'b1;
                                ram_waddr = hit_idx;
                                n_count   = r_count - CNT_W'(1);
                            end
                        end
                        REQ_OLDEST: begin
                            if (!flags.hit) begin
                                n_status = ST_ABSENT;
                            end else begin
                                n_kout    = hit_key;
                                n_iout    = hit_item_out;
                                ram_we    = 1'b1;
                                ram_waddr = hit_idx;
                                n_count   = r_count - CNT_W'(1);
                            end
                        end
                        default: begin
                            n_status = ST_ABSENT;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_next_key  <= FIRST_KEY;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_SCAN);
            r_rd_idx <= r_addr;
            if ((r_state == S_CLEAR) || (r_state == S_SCAN)) begin
                r_addr <= (r_addr == LAST_ADDR) ? '0 : r_addr + ADDR_W'(1);
            end
            if (req_accept) begin
                r_req  <= t_req'(i_req.req_type);
                r_key  <= i_req.key_in;
                r_item <= item_store;
            end
            r_next_key <= n_next_key;
            r_count    <= n_count;
            if (do_result) begin
                r_out_valid <= 1'b1;
                r_status    <= n_status;
                r_kout      <= n_kout;
                r_iout      <= n_iout;
                r_empty     <= (n_count == '0);
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_status;
    assign o_rsp.key_out   = r_kout;
    assign o_rsp.item_out  = r_iout;
    assign o_rsp.empty_res = r_empty;

    // The entry count never passes the table depth.
    `HTAK_ASSERT_ALWAYS(a_count_range, r_count <= CNT_W'(TABLE_DEPTH), "entry count overflow")
    // Once the keys wrap the counter sits at zero; it can never show key one.
    `HTAK_ASSERT_ALWAYS(a_key_not_one, r_next_key != KEY_W'(1), "key counter holds one")
    // A waiting result that reports an empty table agrees with the entry count.
    `HTAK_ASSERT_IMPLIES(a_empty_flag, o_rsp.valid && o_rsp.empty_res, r_count == '0,
        "empty flag disagrees with count")
    // A scan that saw no free slot means every slot is counted as taken.
    `HTAK_ASSERT_IMPLIES(a_full_scan, (r_state == S_WRITE) && !flags.free,
        r_count == CNT_W'(TABLE_DEPTH), "scan found no free slot in a table not full")
endmodule
